[src/pc_pkg.sv]
// Shared types and constants for the streaming Pearson correlation block.
// Used by the controller, the datapath and the top level.
// Depends on nothing.
package pc_pkg;

	localparam int CORR_W  = 16;
	localparam int COUNT_W = 13;
	localparam int BIT_W   = 4;

	typedef logic [3:0] op_t;

	// Products formed by the shared serial multiplier, in issue order.
	localparam op_t OP_N_SXY = 4'd0;
	localparam op_t OP_SX_SY = 4'd1;
	localparam op_t OP_N_SXX = 4'd2;
	localparam op_t OP_SX_SX = 4'd3;
	localparam op_t OP_N_SYY = 4'd4;
	localparam op_t OP_SY_SY = 4'd5;
	localparam op_t OP_VA_VB = 4'd6;
	localparam op_t OP_N_N   = 4'd7;
	localparam op_t OP_SRCH  = 4'd8;

	localparam logic [BIT_W-1:0] SRCH_TOP = 4'd15;

	typedef struct packed {
		logic             start;
		op_t              op;
		logic [BIT_W-1:0] bitk;
		logic             clear_m;
		logic             load_out;
	} pc_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic degenerate;
	} pc_status_t;

endpackage

[src/pc_in_if.sv]
// Input channel: one beat carries a sample pair and the end-of-set mark.
// Depends on nothing.
interface pc_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_x;
	logic signed [SAMPLE_BITS-1:0] sample_y;
	logic                          last;

	modport source (output valid, output sample_x, output sample_y, output last, input ready);
	modport sink   (input valid, input sample_x, input sample_y, input last, output ready);
endinterface

[src/pc_out_if.sv]
// Result channel: one beat per completed set.
// Depends on nothing.
interface pc_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] correlation;
	logic [12:0]        sample_count;
	logic               degenerate;
	logic               overflow;

	modport source (output valid, output correlation, output sample_count,
		output degenerate, output overflow, input ready);
	modport sink   (input valid, input correlation, input sample_count,
		input degenerate, input overflow, output ready);
endinterface

[src/pc_mul.sv]
// Serial shift-add multiplier, one multiplier bit per cycle, signed multiplier.
// Depends on nothing.
module pc_mul #(
	parameter int PW = 152,
	parameter int BW = 59
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [PW-1:0] a,
	input  logic [BW-1:0] b,
	output logic          done,
	output logic [PW-1:0] product
);
	localparam int CNTW = $clog2(BW);

	logic [PW-1:0]   acc_q;
	logic [PW-1:0]   a_q;
	logic [BW-1:0]   b_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic            last_bit;

	assign last_bit = (cnt_q == CNTW'(BW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_bit) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The top multiplier bit carries negative weight, so it subtracts.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= last_bit ? acc_q - a_q : acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= {b_q[BW-1], b_q[BW-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;
endmodule

[src/pc_datapath.sv]
// Datapath: running sums, the variance and covariance terms, the bitwise
// root search and the result register. Depends on pc_pkg and pc_mul.
module pc_datapath #(
	parameter int MAX_SAMPLES = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_beat,
	input  logic signed [SAMPLE_BITS-1:0] sample_x,
	input  logic signed [SAMPLE_BITS-1:0] sample_y,
	input  pc_pkg::pc_cmd_t               cmd,
	output pc_pkg::pc_status_t            status,
	output logic signed [15:0]            correlation,
	output logic [12:0]                   sample_count,
	output logic                          degenerate,
	output logic                          overflow
);
	import pc_pkg::*;

	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int SW = SAMPLE_BITS + CW;
	localparam int QW = 2 * SAMPLE_BITS + CW;
	localparam int VW = 2 * CW + 2 * SAMPLE_BITS;
	localparam int BW = (VW + 1 > 35) ? VW + 1 : 35;
	localparam int PW = 2 * VW + 36;

	logic [CW-1:0]          cnt_q;
	logic signed [SW-1:0]   sx_q, sy_q;
	logic signed [QW-1:0]   sxx_q, syy_q, sxy_q;
	logic                   dropped_q;

	logic signed [2*SAMPLE_BITS-1:0] xx, yy, xy;

	logic [PW-1:0]        t_q, p_q, r_q;
	logic signed [VW-1:0] num_q, va_q, vb_q;
	logic [VW-1:0]        mag;
	logic [CORR_W-1:0]    m_q, cand, cand_q;
	logic [CORR_W:0]      odd;
	logic [2*CORR_W+1:0]  sq;
	op_t                  op_q;

	logic [PW-1:0] mul_a;
	logic [BW-1:0] mul_b;
	logic          mul_done;
	logic [PW-1:0] prod;
	logic          degen;

	logic signed [CORR_W-1:0] corr_q;
	logic [COUNT_W-1:0]       count_out_q;
	logic                     degen_q, ovf_q;

	assign xx = sample_x * sample_x;
	assign yy = sample_y * sample_y;
	assign xy = sample_x * sample_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			sx_q      <= '0;
			sy_q      <= '0;
			sxx_q     <= '0;
			syy_q     <= '0;
			sxy_q     <= '0;
			dropped_q <= 1'b0;
		end else if (cmd.load_out) begin
			cnt_q     <= '0;
			sx_q      <= '0;
			sy_q      <= '0;
			sxx_q     <= '0;
			syy_q     <= '0;
			sxy_q     <= '0;
			dropped_q <= 1'b0;
		end else if (in_beat) begin
			if (cnt_q < CW'(MAX_SAMPLES)) begin
				cnt_q <= cnt_q + 1'b1;
				sx_q  <= sx_q + SW'(sample_x);
				sy_q  <= sy_q + SW'(sample_y);
				sxx_q <= sxx_q + QW'(xx);
				syy_q <= syy_q + QW'(yy);
				sxy_q <= sxy_q + QW'(xy);
			end else begin
				dropped_q <= 1'b1;
			end
		end
	end

	assign mag  = num_q[VW-1] ? VW'(-num_q) : VW'(num_q);
	assign cand = m_q | (CORR_W'(1) << cmd.bitk);
	assign odd  = {cand, 1'b0} - (CORR_W+1)'(1);
	assign sq   = odd * odd;

	always_comb begin
		unique case (cmd.op)
			OP_N_SXY: begin mul_a = PW'(sxy_q); mul_b = BW'(cnt_q); end
			OP_SX_SY: begin mul_a = PW'(sx_q);  mul_b = BW'(sy_q);  end
			OP_N_SXX: begin mul_a = PW'(sxx_q); mul_b = BW'(cnt_q); end
			OP_SX_SX: begin mul_a = PW'(sx_q);  mul_b = BW'(sx_q);  end
			OP_N_SYY: begin mul_a = PW'(syy_q); mul_b = BW'(cnt_q); end
			OP_SY_SY: begin mul_a = PW'(sy_q);  mul_b = BW'(sy_q);  end
			OP_VA_VB: begin mul_a = PW'(va_q);  mul_b = BW'(vb_q);  end
			OP_N_N:   begin mul_a = PW'(mag);   mul_b = BW'(mag);   end
			OP_SRCH:  begin mul_a = p_q;        mul_b = BW'(sq);    end
			default:  begin mul_a = '0;         mul_b = '0;         end
		endcase
	end

	pc_mul #(.PW(PW), .BW(BW)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (prod)
	);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q   <= cmd.op;
			cand_q <= cand;
		end
		if (cmd.clear_m) begin
			m_q <= '0;
		end
		if (mul_done) begin
			unique case (op_q)
				OP_N_SXY, OP_N_SXX, OP_N_SYY: t_q <= prod;
				OP_SX_SY: num_q <= VW'(t_q - prod);
				OP_SX_SX: va_q  <= VW'(t_q - prod);
				OP_SY_SY: vb_q  <= VW'(t_q - prod);
				OP_VA_VB: p_q   <= prod;
				OP_N_N:   r_q   <= prod << 32;
				OP_SRCH: begin
					// Keep the bit when (2m-1)^2 * va * vb <= 2^32 * num^2.
					if (prod <= r_q) begin
						m_q <= cand_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign degen = (va_q == '0) || (vb_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			count_out_q <= COUNT_W'(cnt_q);
			degen_q     <= degen;
			ovf_q       <= dropped_q;
			if (degen) begin
				corr_q <= '0;
			end else if (num_q[VW-1]) begin
				corr_q <= CORR_W'(~m_q + CORR_W'(1));
			end else if (m_q[CORR_W-1]) begin
				corr_q <= {1'b0, {(CORR_W-1){1'b1}}};
			end else begin
				corr_q <= m_q;
			end
		end
	end

	assign status.mul_done   = mul_done;
	assign status.degenerate = degen;
	assign correlation       = corr_q;
	assign sample_count      = count_out_q;
	assign degenerate        = degen_q;
	assign overflow          = ovf_q;
endmodule

[src/pc_ctrl.sv]
// Controller: accepts beats, sequences the multiplier products and the root
// search, and hands the result to the output register. Depends on pc_pkg.
module pc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_last,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  pc_pkg::pc_status_t status,
	output pc_pkg::pc_cmd_t    cmd
);
	import pc_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ISSUE = 3'd1;
	localparam logic [2:0] S_WAIT  = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0]       state_q;
	op_t              op_q;
	logic [BIT_W-1:0] k_q;
	logic             out_valid_q;
	logic             load;

	assign in_ready = (state_q == S_IDLE);
	assign load     = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_N_SXY;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_last) begin
						op_q    <= OP_N_SXY;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (status.mul_done) begin
						state_q <= S_ISSUE;
						case (op_q)
							OP_N_SXY: op_q <= OP_SX_SY;
							OP_SX_SY: op_q <= OP_N_SXX;
							OP_N_SXX: op_q <= OP_SX_SX;
							OP_SX_SX: op_q <= OP_N_SYY;
							OP_N_SYY: op_q <= OP_SY_SY;
							OP_SY_SY: state_q <= S_CHECK;
							OP_VA_VB: op_q <= OP_N_N;
							OP_N_N: begin
								op_q <= OP_SRCH;
								k_q  <= SRCH_TOP;
							end
							default: begin
								if (k_q == '0) begin
									state_q <= S_FIN;
								end else begin
									k_q <= k_q - 1'b1;
								end
							end
						endcase
					end
				end
				S_CHECK: begin
					if (status.degenerate) begin
						state_q <= S_FIN;
					end else begin
						op_q    <= OP_VA_VB;
						state_q <= S_ISSUE;
					end
				end
				S_FIN: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd.start    = (state_q == S_ISSUE);
	assign cmd.op       = op_q;
	assign cmd.bitk     = k_q;
	assign cmd.clear_m  = (state_q == S_CHECK);
	assign cmd.load_out = load;
	assign out_valid    = out_valid_q;
endmodule

[src/pearson_correlation_top.sv]
// Streaming Pearson correlation. Pairs are accepted while idle. A pair
// marked last starts a final pass of 24 serial products on one shift-add
// multiplier whose multiplier operand is BW = max(2*ceil(log2(MAX_SAMPLES+1)) +
// 2*SAMPLE_BITS + 1, 35) bits wide; fewer products when degenerate. Input is
// held off during that pass. Reset clears all sums.
module pearson_correlation_top #(
	parameter int MAX_SAMPLES = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input logic     clk,
	input logic     arst_n,
	pc_in_if.sink   samples,
	pc_out_if.source result
);
	import pc_pkg::*;

	pc_cmd_t    cmd;
	pc_status_t status;

	pc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_last   (samples.last),
		.in_ready  (samples.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	pc_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_beat      (samples.valid && samples.ready),
		.sample_x     (samples.sample_x),
		.sample_y     (samples.sample_y),
		.cmd          (cmd),
		.status       (status),
		.correlation  (result.correlation),
		.sample_count (result.sample_count),
		.degenerate   (result.degenerate),
		.overflow     (result.overflow)
	);
endmodule

[tb/pearson_correlation_top_test.sv]
// Self-checking testbench for pearson_correlation_top: streams sample pairs, predicts
// each set's Q1.15 coefficient with exact wide integer math and checks every result beat.
// Depends on pc_pkg, pc_in_if, pc_out_if and the RTL top level.
module pearson_correlation_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PAIRS = 4096;
	localparam int DRAIN_CYCLES = 3000;

	typedef struct {
		logic signed [pc_pkg::CORR_W-1:0] corr;
		logic [pc_pkg::COUNT_W-1:0]       count;
		logic                             degen;
		logic                             ovf;
	} corr_result_t;

	typedef enum int {MIX_RANDOM, MIX_TRACK, MIX_MIRROR, MIX_FLAT_X, MIX_FLAT_Y, MIX_EXTREME}
		mix_t;

	logic clk;
	logic arst_n;

	pc_in_if #(.SAMPLE_BITS(16)) samples_if ();
	pc_out_if result_if ();

	pearson_correlation_top #(.MAX_SAMPLES(MAX_PAIRS), .SAMPLE_BITS(16)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if.sink),
		.result  (result_if.source)
	);

	// Predictor state.
	int          pair_cnt;
	longint      acc_x, acc_y, acc_xx, acc_yy, acc_xy;
	bit          dropped;
	corr_result_t pending_results[$];

	int  fail_count;
	bit  steady;
	int  stall_reqs;
	int  stall_seen;
	int  stall_left;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		#10_000_000;
		$display("pearson_correlation_top regression: fail");
		$finish;
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic void fold_pair(input logic signed [15:0] x, input logic signed [15:0] y,
			input bit l);
		logic signed [255:0] n, sx, sy, num, va, vb, mag, prod, rhs, lhs, odd;
		corr_result_t res;
		int lo, hi, mid;
		if (pair_cnt < MAX_PAIRS) begin
			acc_x += x;
			acc_y += y;
			acc_xx += longint'(x) * x;
			acc_yy += longint'(y) * y;
			acc_xy += longint'(x) * y;
			pair_cnt++;
		end else begin
			dropped = 1'b1;
		end
		if (!l)
			return;
		n = pair_cnt;
		sx = acc_x;
		sy = acc_y;
		num = n * 256'(signed'(acc_xy)) - sx * sy;
		va = n * 256'(signed'(acc_xx)) - sx * sx;
		vb = n * 256'(signed'(acc_yy)) - sy * sy;
		res.corr = '0;
		res.degen = 1'b0;
		if (va == 0 || vb == 0) begin
			res.degen = 1'b1;
		end else begin
			mag = num < 0 ? -num : num;
			prod = va * vb;
			rhs = (mag * mag) <<< 32;
			lo = 0;
			hi = 32768;
			// Largest m with (2m-1)^2 * va * vb <= 2^32 * num^2 gives round-half-away.
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				odd = 2 * mid - 1;
				lhs = prod * odd * odd;
				if (lhs <= rhs)
					lo = mid;
				else
					hi = mid - 1;
			end
			if (num < 0)
				res.corr = 16'(32'h10000 - lo);
			else
				res.corr = lo > 32767 ? 16'sd32767 : 16'(lo);
		end
		res.count = 13'(pair_cnt);
		res.ovf = dropped;
		pending_results = {pending_results, res};
		pair_cnt = 0;
		acc_x = 0;
		acc_y = 0;
		acc_xx = 0;
		acc_yy = 0;
		acc_xy = 0;
		dropped = 1'b0;
	endfunction

	task automatic send_pair(input logic signed [15:0] x, input logic signed [15:0] y,
			input bit l);
		while (!steady && $urandom_range(99) < 14) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.sample_x <= x;
		samples_if.sample_y <= y;
		samples_if.last <= l;
		do
			@(posedge clk);
		while (!samples_if.ready);
		fold_pair(x, y, l);
	endtask

	task automatic send_set(input int len, input mix_t mix);
		logic signed [15:0] x, y, fx, fy;
		fx = 16'($urandom);
		fy = 16'($urandom);
		for (int i = 0; i < len; i++) begin
			x = 16'($urandom);
			y = 16'($urandom);
			case (mix)
				MIX_TRACK:   y = x + 16'(signed'($urandom_range(64)) - 32);
				MIX_MIRROR:  y = -x + 16'(signed'($urandom_range(8)) - 4);
				MIX_FLAT_X:  x = fx;
				MIX_FLAT_Y:  y = fy;
				MIX_EXTREME: begin
					x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
					y = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
				end
				default: ;
			endcase
			send_pair(x, y, i == len - 1);
		end
	endtask

	// Result receiver: random back-pressure, plus long hold-offs on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			stall_seen <= 0;
			stall_left <= 0;
		end else if (stall_reqs != stall_seen) begin
			stall_seen <= stall_reqs;
			stall_left <= 6000;
			result_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= steady || ($urandom_range(99) >= 14);
		end
	end

	always @(posedge clk) begin
		corr_result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_results.size() == 0) begin
				report("unexpected result beat", result_if.correlation, 0);
			end else begin
				want = pending_results.pop_front();
				if (result_if.correlation !== want.corr)
					report("correlation", result_if.correlation, want.corr);
				if (result_if.sample_count !== want.count)
					report("sample_count", result_if.sample_count, want.count);
				if (result_if.degenerate !== want.degen)
					report("degenerate", result_if.degenerate, want.degen);
				if (result_if.overflow !== want.ovf)
					report("overflow", result_if.overflow, want.ovf);
			end
		end
	end

	task automatic test_directed();
		send_pair(16'sd1234, -16'sd77, 1'b1);              // single pair is degenerate
		send_pair(16'sh8000, 16'sh8000, 1'b0);             // perfect positive saturates
		send_pair(16'sh7fff, 16'sh7fff, 1'b1);
		send_pair(16'sh8000, 16'sh7fff, 1'b0);             // perfect negative
		send_pair(16'sh7fff, 16'sh8000, 1'b1);
		send_pair(16'sd5, 16'sd1, 1'b0);                   // flat x
		send_pair(16'sd5, 16'sd9, 1'b0);
		send_pair(16'sd5, -16'sd3, 1'b1);
		send_pair(16'sd1, -16'sd2, 1'b0);                  // flat y
		send_pair(-16'sd9, -16'sd2, 1'b1);
		send_pair(16'sd0, 16'sd0, 1'b0);                   // all zero
		send_pair(16'sd0, 16'sd0, 1'b1);
		send_pair(16'sd1, 16'sd2, 1'b0);                   // partial correlation
		send_pair(16'sd2, 16'sd1, 1'b0);
		send_pair(16'sd3, 16'sd4, 1'b1);
		send_pair(16'shffff, 16'sh0001, 1'b0);
		send_pair(16'sh5555, 16'shaaaa, 1'b0);
		send_pair(16'sh0001, 16'shffff, 1'b1);
	endtask

	task automatic test_backpressure();
		stall_reqs++;
		for (int i = 0; i < 6; i++)
			send_set($urandom_range(1, 4), MIX_RANDOM);
	endtask

	task automatic test_random();
		int sent;
		int len;
		sent = 0;
		while (sent < 450) begin
			len = $urandom_range(99) < 90 ? $urandom_range(1, 16) : $urandom_range(30, 80);
			send_set(len, mix_t'($urandom_range(5)));
			sent += len;
			steady = sent > 150 && sent < 250;
		end
		steady = 1'b0;
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		samples_if.valid = 1'b0;
		samples_if.sample_x = '0;
		samples_if.sample_y = '0;
		samples_if.last = 1'b0;
		fail_count = 0;
		steady = 1'b0;
		stall_reqs = 0;
		pair_cnt = 0;
		acc_x = 0;
		acc_y = 0;
		acc_xx = 0;
		acc_yy = 0;
		acc_xy = 0;
		dropped = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		samples_if.valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("pearson_correlation_top regression: pass");
		else
			$display("pearson_correlation_top regression: fail");
		$finish;
	end

endmodule
